// ===== rtl/raster_timing_generator_defines.svh =====
// Assertion macros for the raster timing generator.
// Used by raster_timing_generator.sv; expects clk and arst_n in scope.
`ifndef RASTER_TIMING_GENERATOR_DEFINES_SVH
`define RASTER_TIMING_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define RTG_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("raster timing generator check failed");
`define RTG_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("raster timing generator forbidden condition");
`else
`define RTG_ASSERT(lbl, prop)
`define RTG_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/rtg_pkg.sv =====
// Shared types and constants for the raster timing generator.
// No dependencies; imported by raster_timing_generator.
`timescale 1ns / 1ps

package rtg_pkg;

	localparam int CYCLES_PER_LINE_DEF = 64;
	localparam int VISIBLE_LINES_DEF   = 224;
	localparam int FRAME_LINES_DEF     = 312;
	localparam int LAST_COLUMN_DEF     = 40;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_CORE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PER_CYCLE_RENDER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FETCH_OFFSET     = 2'd2;

	localparam logic CMD_ADVANCE     = 1'b0;
	localparam logic CMD_FRAME_BEGIN = 1'b1;

	typedef struct packed {
		logic       command;
		logic [4:0] cycles;
	} item_t;

	typedef struct packed {
		logic [9:0] beam_line;
		logic [5:0] beam_dot;
		logic       line_begin;
		logic       fetch_valid;
		logic [5:0] fetch_column;
		logic       line_end;
		logic       render_valid;
		logic [7:0] render_line;
		logic       tick_valid;
		logic [8:0] tick_line;
	} result_t;

endpackage

// ===== rtl/raster_timing_generator.sv =====
// Raster timing generator: one-pass beam clock with input and result registers.
// Depends on rtg_pkg and raster_timing_generator_defines.svh.
//
// Throughput is one item per cycle unless a held result waits for result_ready, set
// by the single pass from the input register through the beam position adder and
// boundary compare into the result register. The beam is kept as line and dot
// counters next to the 16-bit position, so no divider is used.
`timescale 1ns / 1ps
`include "raster_timing_generator_defines.svh"

module raster_timing_generator #(
	parameter int CYCLES_PER_LINE = rtg_pkg::CYCLES_PER_LINE_DEF,
	parameter int VISIBLE_LINES   = rtg_pkg::VISIBLE_LINES_DEF,
	parameter int FRAME_LINES     = rtg_pkg::FRAME_LINES_DEF,
	parameter int LAST_COLUMN     = rtg_pkg::LAST_COLUMN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  rtg_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output rtg_pkg::result_t                 result,
	input  logic                             wr_en,
	input  logic [rtg_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [rtg_pkg::CFG_DATA_W-1:0]   wr_data
);
	import rtg_pkg::*;

	localparam int POS_MAX  = 65535;
	localparam int DOT_W    = $clog2(CYCLES_PER_LINE);
	localparam int LINE_MAX = POS_MAX / CYCLES_PER_LINE;
	localparam int LINE_W   = $clog2(LINE_MAX + 1);
	localparam int SAT_DOT  = POS_MAX % CYCLES_PER_LINE;

	logic        cycle_core_q;
	logic        per_cycle_render_q;
	logic [5:0]  fetch_offset_q;

	logic [15:0]       pos_q;
	logic [15:0]       boundary_q;
	logic [7:0]        lines_q;
	logic [8:0]        tick_q;
	logic [LINE_W-1:0] line_q;
	logic [DOT_W-1:0]  dot_q;

	logic    s1_valid_q;
	item_t   item_s1;
	logic    res_valid_q;
	result_t res_q;

	logic fire;

	logic              per_cycle;
	logic              visible;
	logic [4:0]        n;
	logic [16:0]       pos_sum;
	logic [15:0]       pos_next;
	logic              crossing;
	logic [16:0]       bnd_sum;
	logic [DOT_W:0]    dot_sum;
	logic [8:0]        fetch_diff;
	logic              fetch_hit;
	logic              at_line_end;
	logic [7:0]        lines_after_pc;
	logic              do_render;
	logic              do_tick;
	result_t           res_d;

	assign fire         = s1_valid_q && (!res_valid_q || result_ready);
	assign item_ready   = !s1_valid_q || fire;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_core_q       <= 1'b1;
			per_cycle_render_q <= 1'b0;
			fetch_offset_q     <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_CYCLE_CORE:       cycle_core_q       <= wr_data[0];
				CFG_PER_CYCLE_RENDER: per_cycle_render_q <= wr_data[0];
				CFG_FETCH_OFFSET:     fetch_offset_q     <= wr_data;
				default: ;
			endcase
		end
	end

	// one pass over the held item
	always_comb begin
		per_cycle   = cycle_core_q && per_cycle_render_q;
		visible     = 32'(line_q) < VISIBLE_LINES;
		n           = cycle_core_q ? 5'd1 : ((item_s1.cycles > 5'd16) ? 5'd16 : item_s1.cycles);
		pos_sum     = {1'b0, pos_q} + 17'(n);
		pos_next    = pos_sum[16] ? 16'hFFFF : pos_sum[15:0];
		crossing    = (pos_q < boundary_q) && (pos_next >= boundary_q);
		bnd_sum     = {1'b0, boundary_q} + 17'(CYCLES_PER_LINE);
		dot_sum     = {1'b0, dot_q} + (DOT_W+1)'(n);
		fetch_diff  = 9'(dot_q) - 9'(fetch_offset_q);
		fetch_hit   = (9'(dot_q) >= 9'(fetch_offset_q)) && (fetch_diff <= 9'(LAST_COLUMN));
		at_line_end = 32'(dot_q) == CYCLES_PER_LINE - 1;
		lines_after_pc = 8'(line_q + LINE_W'(1));
		do_render   = crossing && !per_cycle && (32'(lines_q) < VISIBLE_LINES);
		do_tick     = crossing && (32'(tick_q) < FRAME_LINES);

		res_d              = '0;
		res_d.beam_line    = 10'(line_q);
		res_d.beam_dot     = 6'(dot_q);
		if (item_s1.command == CMD_ADVANCE) begin
			if (per_cycle && visible) begin
				res_d.line_begin = dot_q == '0;
				res_d.line_end   = at_line_end;
				if (fetch_hit) begin
					res_d.fetch_valid  = 1'b1;
					res_d.fetch_column = fetch_diff[5:0];
				end
			end
			if (do_render) begin
				res_d.render_valid = 1'b1;
				res_d.render_line  = lines_q;
			end
			if (do_tick) begin
				res_d.tick_valid = 1'b1;
				res_d.tick_line  = tick_q;
			end
		end
	end

	// beam state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			boundary_q <= 16'(CYCLES_PER_LINE);
			lines_q    <= '0;
			tick_q     <= '0;
			line_q     <= '0;
			dot_q      <= '0;
		end else if (fire) begin
			if (item_s1.command == CMD_FRAME_BEGIN) begin
				pos_q      <= '0;
				boundary_q <= 16'(CYCLES_PER_LINE);
				lines_q    <= '0;
				tick_q     <= '0;
				line_q     <= '0;
				dot_q      <= '0;
			end else begin
				pos_q <= pos_next;
				if (pos_sum[16]) begin
					line_q <= LINE_W'(LINE_MAX);
					dot_q  <= DOT_W'(SAT_DOT);
				end else if (dot_sum >= (DOT_W+1)'(CYCLES_PER_LINE)) begin
					line_q <= line_q + LINE_W'(1);
					dot_q  <= DOT_W'(dot_sum - (DOT_W+1)'(CYCLES_PER_LINE));
				end else begin
					dot_q <= dot_sum[DOT_W-1:0];
				end
				if (per_cycle && visible && at_line_end) begin
					lines_q <= lines_after_pc;
				end else if (do_render) begin
					lines_q <= lines_q + 8'd1;
				end
				if (do_tick) begin
					tick_q <= tick_q + 9'd1;
				end
				if (crossing) begin
					boundary_q <= bnd_sum[16] ? 16'hFFFF : bnd_sum[15:0];
				end
			end
		end
	end

	// input and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				s1_valid_q <= item_valid;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (fire) begin
			res_q <= res_d;
		end
	end

	`RTG_ASSERT(a_accept_fills_stage, item_valid && item_ready |=> s1_valid_q)
	`RTG_ASSERT(a_dot_in_line, 32'(dot_q) < CYCLES_PER_LINE)
	`RTG_ASSERT(a_tick_bounded, 32'(tick_q) <= FRAME_LINES)
	`RTG_ASSERT_NEVER(a_render_vs_per_cycle,
		result_valid && result.render_valid && (result.line_begin || result.line_end))

endmodule
